// ===== hw/rtl/trial_division_prime_test_macros.svh =====
// Assertion helpers for the prime test block
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// property checked on every clock edge outside reset
`define TDPT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent holds, consequent must hold in the following cycle
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tdpt_pkg.sv =====
package tdpt_pkg;

   localparam int unsigned NUMBER_WIDTH_DEFAULT = 16;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic next_d;
   } tdpt_cmd_type;

   typedef struct packed {
      logic below_two;
      logic over_half;
      logic div_last;
      logic rem_zero;
   } tdpt_status_type;

endpackage

// ===== hw/rtl/tdpt_dp.sv =====
module tdpt_dp #(
   parameter int unsigned NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic [NUMBER_WIDTH-1:0]   candidate,
   input  tdpt_pkg::tdpt_cmd_type    cmd,
   output tdpt_pkg::tdpt_status_type status
);
   import tdpt_pkg::*;

   localparam int unsigned CntWidth = $clog2(NUMBER_WIDTH);
   localparam logic [CntWidth-1:0] LastBit = CntWidth'(NUMBER_WIDTH - 1);

   logic [NUMBER_WIDTH-1:0] n_ff, n_in;
   logic [NUMBER_WIDTH-1:0] d_ff, d_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] shift_ff, shift_in;
   logic [CntWidth-1:0]     cnt_ff, cnt_in;

   logic [NUMBER_WIDTH:0]   rem_shift;
   logic [NUMBER_WIDTH:0]   diff;
   logic [NUMBER_WIDTH-1:0] half;

   // restoring division, one quotient bit per cycle
   assign rem_shift = {rem_ff, shift_ff[NUMBER_WIDTH-1]};
   assign diff      = rem_shift - {1'b0, d_ff};
   assign half      = n_ff >> 1;

   always_comb begin
      n_in     = n_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         n_in = candidate;
         d_in = NUMBER_WIDTH'(2);
      end
      if (cmd.div_init) begin
         rem_in   = '0;
         shift_in = n_ff;
         cnt_in   = '0;
      end
      if (cmd.div_step) begin
         rem_in   = diff[NUMBER_WIDTH] ? rem_shift[NUMBER_WIDTH-1:0] : diff[NUMBER_WIDTH-1:0];
         shift_in = shift_ff << 1;
         cnt_in   = cnt_ff + 1'b1;
      end
      if (cmd.next_d) begin
         d_in = d_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
   end

   assign status.below_two = (half == '0) && !n_ff[0] ? 1'b1 : (half == '0);
   assign status.over_half = d_ff > half;
   assign status.div_last  = cnt_ff == LastBit;
   assign status.rem_zero  = rem_ff == '0;

endmodule

// ===== hw/rtl/tdpt_ctrl.sv =====
module tdpt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_is_prime,
   input  tdpt_pkg::tdpt_status_type status,
   output tdpt_pkg::tdpt_cmd_type    cmd
);
   import tdpt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRY,
      ST_DIV,
      ST_EVAL,
      ST_RESULT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_is_prime_ff;
   logic      result_ff;

   assign req_stall    = state_ff != ST_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   assign cmd.load     = (state_ff == ST_IDLE) && req_valid;
   assign cmd.div_init = (state_ff == ST_TRY) && !status.below_two && !status.over_half;
   assign cmd.div_step = state_ff == ST_DIV;
   assign cmd.next_d   = (state_ff == ST_EVAL) && !status.rem_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff    <= 1'b1;
            rsp_is_prime_ff <= result_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_TRY;
               end
            end
            ST_TRY: begin
               if (status.below_two) begin
                  result_ff <= 1'b0;
                  state_ff  <= ST_RESULT;
               end else if (status.over_half) begin
                  result_ff <= 1'b1;
                  state_ff  <= ST_RESULT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (status.div_last) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (status.rem_zero) begin
                  result_ff <= 1'b0;
                  state_ff  <= ST_RESULT;
               end else begin
                  state_ff <= ST_TRY;
               end
            end
            ST_RESULT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/trial_division_prime_test.sv =====
// Trial-division prime test, one candidate at a time.
// Candidates below two are reported not prime, and 2 and 3 prime, without any division.
// Otherwise each trial divisor, counting up from 2, runs a bit-serial restoring remainder unit;
// the test stops at the first divisor with zero remainder (composite) or once the divisor
// exceeds half the candidate (prime). A new candidate is taken only once the last is finished;
// a finished result may wait while the next is taken.
// Synchronous active-high reset returns the controller to idle with no result pending.
module trial_division_prime_test #(
   parameter int unsigned NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_prime
);
   import tdpt_pkg::*;

   tdpt_cmd_type    cmd;
   tdpt_status_type status;

   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime),
      .status       (status),
      .cmd          (cmd)
   );

   tdpt_dp #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_dp (
      .clock     (clock),
      .candidate (req_candidate),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== hw/rtl/tdpt_checker.sv =====
`include "trial_division_prime_test_macros.svh"

module tdpt_checker #(
   parameter int unsigned NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [NUMBER_WIDTH-1:0] req_candidate,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_is_prime
);

   logic req_accept;
   logic tiny_accept;

   assign req_accept  = req_valid && !req_stall;
   assign tiny_accept = req_accept && !rsp_valid && ((req_candidate >> 2) == '0);

   // one transaction in flight
   `TDPT_ASSERT_NEXT(a_busy_after_accept, req_accept, req_stall, "input taken while busy")

   // a candidate below four, taken with no result pending, is answered without division: 2 and 3 prime, 0 and 1 not
   `TDPT_ASSERT_NEXT(a_tiny_result, tiny_accept, ##2 (rsp_valid && (rsp_is_prime == $past(req_candidate[1], 3))), "wrong result for candidate below four")

   `TDPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_is_prime), "stalled result changed")

   `TDPT_ASSERT(a_no_known_x, !$isunknown(req_stall) && !$isunknown(rsp_valid), "control outputs unknown")

endmodule

bind trial_division_prime_test tdpt_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_tdpt_checker (.*);

// ===== tb/prime_result_checker.sv =====
module prime_result_checker #(
   parameter int unsigned NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_candidate,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_is_prime,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic                    expected_prime_flags[$];
   logic [NUMBER_WIDTH-1:0] candidates_in_flight[$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   function automatic logic prime_by_trial(logic [NUMBER_WIDTH-1:0] candidate);
      longint unsigned value;
      longint unsigned divisor;
      value = candidate;
      if (value < 2) return 1'b0;
      for (divisor = 2; divisor <= value / 2; divisor++) begin
         if (value % divisor == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : track
      logic                    want;
      logic [NUMBER_WIDTH-1:0] candidate;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_prime_flags.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, is_prime=%0b", rsp_is_prime));
            end else begin
               want = expected_prime_flags.pop_front();
               candidate = candidates_in_flight.pop_front();
               if (rsp_is_prime !== want)
                  report_mismatch($sformatf("candidate %0d: is_prime=%0b, expected %0b",
                                            candidate, rsp_is_prime, want));
            end
         end
         if (req_valid && !req_stall) begin
            expected_prime_flags.push_back(prime_by_trial(req_candidate));
            candidates_in_flight.push_back(req_candidate);
         end
      end
      pending = expected_prime_flags.size();
   end

endmodule

// ===== tb/trial_division_prime_test_tb.sv =====
module trial_division_prime_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WIDTH = tdpt_pkg::NUMBER_WIDTH_DEFAULT;
   localparam int unsigned RANDOM_ITEMS = 65;
   localparam int unsigned LONG_HOLD_CYCLES = 2000;
   localparam int unsigned TAIL_CYCLES = 60;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_style_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [WIDTH-1:0] req_candidate;
   logic             rsp_valid;
   logic             rsp_stall;
   logic             rsp_is_prime;
   int               fail_count;
   int               pending;
   int               burst_left = 0;
   bit               long_hold_req = 1'b0;
   bit               long_hold_active = 1'b0;
   bit               long_hold_done = 1'b0;

   trial_division_prime_test #(
      .NUMBER_WIDTH(WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_candidate(req_candidate),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_prime(rsp_is_prime)
   );

   prime_result_checker #(
      .NUMBER_WIDTH(WIDTH)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_candidate(req_candidate),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_is_prime(rsp_is_prime),
      .fail_count(fail_count),
      .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #100_000_000;
      $display("status: fail");
      $finish;
   end

   // receiver: random stall segments, one long hold on request
   initial begin
      stall_style_type style;
      int              span;
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_req && !long_hold_done) begin
            rsp_stall <= 1'b1;
            long_hold_active = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_active = 1'b0;
            long_hold_done = 1'b1;
         end else begin
            style = stall_style_type'($urandom_range(STALL_NONE, STALL_HEAVY));
            span = $urandom_range(1, 40);
            repeat (span) begin
               case (style)
                  STALL_NONE: rsp_stall <= 1'b0;
                  STALL_HALF: rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic offer_candidate(input logic [WIDTH-1:0] value);
      req_valid <= 1'b1;
      req_candidate <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // mostly small values; the widest draws are multiples of three so they finish fast
   function automatic logic [WIDTH-1:0] pick_candidate();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return WIDTH'($urandom_range(0, 255));
      if (roll < 80) return WIDTH'($urandom_range(256, 2047));
      return WIDTH'(3 * $urandom_range(1, 21845));
   endfunction

   initial begin
      logic [WIDTH-1:0] directed[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_candidate = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 25, 49, 97, 121, 251, 253, 255, 256,
                   257, 21845, 32767, 32768, 65534, 65535, 65521};
      foreach (directed[i]) begin
         offer_candidate(directed[i]);
         pace_sender();
      end

      drain_results();
      long_hold_req = 1'b1;
      wait (long_hold_active);
      @(posedge clock);
      repeat (10) offer_candidate(WIDTH'($urandom_range(0, 60)));
      drain_results();

      repeat (RANDOM_ITEMS) begin
         offer_candidate(pick_candidate());
         pace_sender();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== trial_division_prime_test.f =====
+incdir+hw/rtl
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_dp.sv
hw/rtl/tdpt_ctrl.sv
hw/rtl/trial_division_prime_test.sv
hw/rtl/tdpt_checker.sv
tb/prime_result_checker.sv
tb/trial_division_prime_test_tb.sv
